// ===== hw/rtl/utp_pkg.sv =====
// Shared types, character codes and the hex digit decoder for the UUID text parser.
package utp_pkg;

   // Body length and offsets of the dash separators
   localparam logic [5:0] BODY_LEN = 6'd36;
   localparam logic [5:0] DASH_0   = 6'd8;
   localparam logic [5:0] DASH_1   = 6'd13;
   localparam logic [5:0] DASH_2   = 6'd18;
   localparam logic [5:0] DASH_3   = 6'd23;

   // Character codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_LBRACE = 8'h7b;
   localparam logic [7:0] CHAR_RBRACE = 8'h7d;
   localparam logic [7:0] CHAR_DASH   = 8'h2d;

   // Decoder answer for a byte that is not a hex digit
   localparam logic [4:0] HEX_INVALID = 5'd16;

   typedef struct packed {
      logic [63:0] uuid_upper;
      logic [63:0] uuid_lower;
      logic        valid_res;
   } rsp_type;

   // Digit value 0..15, or HEX_INVALID
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = HEX_INVALID;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

// ===== hw/rtl/utp_if.sv =====
// Valid/ready channel interfaces for characters in and parsed UUIDs out.
interface utp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface utp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] uuid_upper;
   logic [63:0] uuid_lower;
   logic        valid_res;

   modport source (output valid, output uuid_upper, output uuid_lower, output valid_res,
                   input ready);
   modport sink   (input valid, input uuid_upper, input uuid_lower, input valid_res,
                   output ready);
endinterface

// ===== hw/rtl/utp_parse.sv =====
// Parser state registers and per-character next-state logic.
module utp_parse
   import utp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  character,
   output rsp_type     result
);

   logic [5:0]  position_ff, position_in;
   logic        braced_ff, braced_in;
   logic        failed_ff, failed_in;
   logic [63:0] acc_upper_ff, acc_upper_in;
   logic [63:0] acc_lower_ff, acc_lower_in;
   logic [4:0]  digit;
   logic [5:0]  want;
   logic        ok;

   assign digit = hex_value(character);

   // Result seen on a terminating NUL
   always_comb begin
      want = braced_ff ? (BODY_LEN + 6'd1) : BODY_LEN;
      ok   = !failed_ff && (position_ff == want);
      result.uuid_upper = ok ? acc_upper_ff : 64'd0;
      result.uuid_lower = ok ? acc_lower_ff : 64'd0;
      result.valid_res  = ok;
   end

   // Next state for one character
   always_comb begin
      position_in  = position_ff;
      braced_in    = braced_ff;
      failed_in    = failed_ff;
      acc_upper_in = acc_upper_ff;
      acc_lower_in = acc_lower_ff;
      if (character == CHAR_NUL) begin
         position_in  = '0;
         braced_in    = 1'b0;
         failed_in    = 1'b0;
         acc_upper_in = '0;
         acc_lower_in = '0;
      end else if (failed_ff) begin
         // hold until the terminator
      end else if (position_ff == 6'd0 && !braced_ff && character == CHAR_LBRACE) begin
         braced_in = 1'b1;
      end else if (position_ff < BODY_LEN) begin
         if (position_ff inside {DASH_0, DASH_1, DASH_2, DASH_3}) begin
            if (character != CHAR_DASH) begin
               failed_in = 1'b1;
            end else begin
               position_in = position_ff + 6'd1;
            end
         end else if (digit == HEX_INVALID) begin
            failed_in = 1'b1;
         end else begin
            acc_upper_in = {acc_upper_ff[59:0], acc_lower_ff[63:60]};
            acc_lower_in = {acc_lower_ff[59:0], digit[3:0]};
            position_in  = position_ff + 6'd1;
         end
      end else if (position_ff == BODY_LEN && braced_ff && character == CHAR_RBRACE) begin
         position_in = position_ff + 6'd1;
      end else begin
         failed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         braced_ff    <= 1'b0;
         failed_ff    <= 1'b0;
         acc_upper_ff <= '0;
         acc_lower_ff <= '0;
      end else if (step) begin
         position_ff  <= position_in;
         braced_ff    <= braced_in;
         failed_ff    <= failed_in;
         acc_upper_ff <= acc_upper_in;
         acc_lower_ff <= acc_lower_in;
      end
   end

endmodule

// ===== hw/rtl/utp_rsp_reg.sv =====
// Result register that holds a parsed UUID until the receiver takes it.
module utp_rsp_reg
   import utp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_type       data,
   output logic          free,
   utp_rsp_if.source     rsp_chan
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Slot can take a new result when empty or drained this cycle
   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.uuid_upper = data_ff.uuid_upper;
   assign rsp_chan.uuid_lower = data_ff.uuid_lower;
   assign rsp_chan.valid_res  = data_ff.valid_res;

endmodule

// ===== hw/rtl/uuid_text_parser_unit.sv =====
// UUID text parser: top level with input register, parser and result register.
//
// Usage: characters of a UUID string arrive on req_chan, one per transfer, as
// XXXXXXXX-XXXX-XXXX-XXXX-XXXXXXXXXXXX, optionally wrapped in braces. A NUL
// character ends the string and produces exactly one transfer on rsp_chan:
// the 128-bit value split into uuid_upper and uuid_lower plus valid_res. A
// malformed string yields zeros with valid_res low. Other characters produce
// no result.
// Throughput: one character per cycle, sustained, with no gaps between
// strings, while the result register has room for each NUL. Each character
// is held in the input register, then folded into the parser state; a NUL
// result passes into the result register and is offered on rsp_chan from there.
// Stall: while the receiver holds rsp_chan.ready low with a result pending,
// ordinary characters keep flowing; only the next NUL waits in the input
// register, and req_chan.ready drops behind it.
// Reset: synchronous, active high; clears the parser state, empties both
// registers and drops rsp_chan.valid.
module uuid_text_parser_unit
   import utp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   utp_req_if.sink   req_chan,
   utp_rsp_if.source rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       out_free;
   logic       step;
   logic       req_xfer;
   rsp_type    result;

   // A held NUL needs room in the result register; other characters never wait
   assign step            = in_valid_ff && ((in_char_ff != CHAR_NUL) || out_free);
   assign req_chan.ready  = !in_valid_ff || step;
   assign req_xfer        = req_chan.valid && req_chan.ready;
   assign in_valid_in     = req_xfer || (in_valid_ff && !step);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_char_ff <= req_chan.character;
      end
   end

   utp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .character (in_char_ff),
      .result    (result)
   );

   utp_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (step && (in_char_ff == CHAR_NUL)),
      .data     (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
